/* hw/rtl/bps_pkg.sv */
`default_nettype none

package bps_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_REPEAT_TOTAL   = 1'b1;

  localparam logic [4:0] PATTERN_LENGTH_RESET = 5'd0;
  localparam logic [7:0] REPEAT_TOTAL_RESET   = 8'd1;
  localparam logic [7:0] REPEAT_MAX           = 8'd255;

  // Packed from the lowest bit up: buzzer_level, busy_res, entry_now, finished.
  typedef struct packed {
    logic       finished;
    logic [3:0] entry_now;
    logic       busy_res;
    logic       buzzer_level;
  } bps_result_t;

  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    logic [3:0] raddr;
  } bps_tbl_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/bps_table.sv */
`default_nettype none

module bps_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 16
) (
  input  wire                       clk,
  input  bps_pkg::bps_tbl_ctl_t     ctl,
  input  wire  [TIME_WIDTH-1:0]     wr_on,
  input  wire  [TIME_WIDTH-1:0]     wr_off,
  output logic [TIME_WIDTH-1:0]     rd_on,
  output logic [TIME_WIDTH-1:0]     rd_off
);
  import bps_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [TIME_WIDTH-1:0] on_mem  [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] off_mem [TABLE_DEPTH];

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              bypass;

  assign waddr  = ADDR_W'(ctl.waddr);
  assign raddr  = ADDR_W'(ctl.raddr);
  assign bypass = ctl.we && (ctl.waddr == ctl.raddr);

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      on_mem[waddr]  <= wr_on;
      off_mem[waddr] <= wr_off;
    end
    if (bypass) begin
      rd_on  <= wr_on;
      rd_off <= wr_off;
    end else begin
      rd_on  <= on_mem[raddr];
      rd_off <= off_mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bps_seq.sv */
`default_nettype none

module bps_seq #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        go,
  input  bps_pkg::cmd_t              cmd,
  input  wire  [3:0]                 idx,
  input  wire  [4:0]                 pattern_length,
  input  wire  [7:0]                 repeat_total,
  input  wire  [TIME_WIDTH-1:0]      rd_on,
  input  wire  [TIME_WIDTH-1:0]      rd_off,
  output bps_pkg::bps_tbl_ctl_t      tbl_ctl,
  output bps_pkg::bps_result_t       result
);
  import bps_pkg::*;

  logic [3:0]            entry_counter, entry_counter_next;
  logic [7:0]            repeat_counter, repeat_counter_next;
  logic                  on_phase, on_phase_next;
  logic                  playing, playing_next;
  logic [TIME_WIDTH-1:0] phase_elapsed, phase_elapsed_next;

  logic [TIME_WIDTH-1:0] limit;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [7:0]            passes;
  logic [7:0]            repeat_inc;
  logic [4:0]            entry_plus;
  logic                  wrap;
  logic                  done;
  logic                  load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_counter  <= '0;
      repeat_counter <= '0;
      on_phase       <= 1'b1;
      playing        <= 1'b0;
      phase_elapsed  <= '0;
    end else if (go) begin
      entry_counter  <= entry_counter_next;
      repeat_counter <= repeat_counter_next;
      on_phase       <= on_phase_next;
      playing        <= playing_next;
      phase_elapsed  <= phase_elapsed_next;
    end
  end

  always_comb begin
    limit       = on_phase ? rd_on : rd_off;
    elapsed_inc = (&phase_elapsed) ? phase_elapsed : phase_elapsed + TIME_WIDTH'(1);
    passes      = (repeat_total == 8'd0) ? 8'd1 : repeat_total;
    repeat_inc  = (repeat_counter == REPEAT_MAX) ? repeat_counter : repeat_counter + 8'd1;
    entry_plus  = {1'b0, entry_counter} + 5'd1;
    wrap        = (entry_plus >= pattern_length) ||
                  (32'(entry_plus) >= 32'(TABLE_DEPTH));
    load_ok     = !playing && (32'(idx) < 32'(TABLE_DEPTH));

    entry_counter_next  = entry_counter;
    repeat_counter_next = repeat_counter;
    on_phase_next       = on_phase;
    playing_next        = playing;
    phase_elapsed_next  = phase_elapsed;
    done                = 1'b0;
    tbl_ctl.we          = 1'b0;

    case (cmd)
      CMD_TICK: begin
        if (playing) begin
          phase_elapsed_next = elapsed_inc;
          if (elapsed_inc >= limit) begin
            phase_elapsed_next = '0;
            if (on_phase) begin
              on_phase_next = 1'b0;
            end else if (wrap) begin
              repeat_counter_next = repeat_inc;
              if (repeat_inc >= passes) begin
                entry_counter_next = '0;
                playing_next       = 1'b0;
                done               = 1'b1;
              end else begin
                entry_counter_next = '0;
                on_phase_next      = 1'b1;
              end
            end else begin
              entry_counter_next = entry_plus[3:0];
              on_phase_next      = 1'b1;
            end
          end
        end
      end
      CMD_LOAD: begin
        tbl_ctl.we = go && load_ok;
      end
      CMD_START: begin
        if ((pattern_length != 5'd0) && (32'(pattern_length) <= 32'(TABLE_DEPTH))) begin
          entry_counter_next  = '0;
          repeat_counter_next = '0;
          on_phase_next       = 1'b1;
          playing_next        = 1'b1;
          phase_elapsed_next  = '0;
        end
      end
      CMD_STOP: begin
        playing_next = 1'b0;
      end
      default: begin
        playing_next = playing;
      end
    endcase

    tbl_ctl.waddr = idx;
    tbl_ctl.raddr = go ? entry_counter_next : entry_counter;

    result.buzzer_level = playing_next && on_phase_next;
    result.busy_res     = playing_next;
    result.entry_now    = entry_counter_next;
    result.finished     = done;
  end

endmodule

`default_nettype wire

/* hw/rtl/beep_pattern_sequencer.sv */
`default_nettype none

// Beep pattern sequencer: plays a table of on/off tick durations on a buzzer,
// repeating the pattern a configured number of times. Every item on the input
// stream (tick, load, start or stop) produces exactly one status result. The
// block takes one item per clock while the result side is not stalled, and
// passes it through the input register, where the item is applied to the
// sequencer state and the pattern table, and then the result register. The
// pattern table is a memory with a registered read port that is always
// addressed with the entry the next item will play, so consecutive ticks run
// at full rate. The configuration registers may only be written while no item
// is in flight.
module beep_pattern_sequencer #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // entry_index, on_duration, off_duration, zero pad
  input  wire  [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // buzzer_level, busy_res, entry_now, finished, zero pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [7:0]  cfg_data
);
  import bps_pkg::*;

  logic [4:0]            pattern_length;
  logic [7:0]            repeat_total;

  logic                  in_valid;
  cmd_t                  in_cmd;
  logic [3:0]            in_idx;
  logic [TIME_WIDTH-1:0] in_on;
  logic [TIME_WIDTH-1:0] in_off;

  logic                  out_valid;
  bps_result_t           out_result;

  logic                  go;
  bps_tbl_ctl_t          tbl_ctl;
  bps_result_t           result;
  logic [TIME_WIDTH-1:0] rd_on;
  logic [TIME_WIDTH-1:0] rd_off;

  assign cfg_ready = 1'b1;
  assign go        = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || go;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PATTERN_LENGTH_RESET;
      repeat_total   <= REPEAT_TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data[4:0];
      end else begin
        repeat_total <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= cmd_t'(s_tuser);
      in_idx <= s_tdata[3:0];
      in_on  <= TIME_WIDTH'(s_tdata[19:4]);
      in_off <= TIME_WIDTH'(s_tdata[35:20]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_result <= result;
    end
  end

  bps_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .cmd            (in_cmd),
    .idx            (in_idx),
    .pattern_length (pattern_length),
    .repeat_total   (repeat_total),
    .rd_on          (rd_on),
    .rd_off         (rd_off),
    .tbl_ctl        (tbl_ctl),
    .result         (result)
  );

  bps_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_table (
    .clk    (clk),
    .ctl    (tbl_ctl),
    .wr_on  (in_on),
    .wr_off (in_off),
    .rd_on  (rd_on),
    .rd_off (rd_off)
  );

endmodule

`default_nettype wire

/* hw/rtl/bps_checker.sv */
`default_nettype none

module bps_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed.");

  a_buzzer_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("Buzzer sounding while not playing.");

  a_finished_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> !m_tdata[1] && (m_tdata[5:2] == 4'd0))
    else $error("Finished result does not show an idle block at entry zero.");

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/beep_pattern_sequencer_tb.sv */
`default_nettype none

module beep_pattern_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TARGET_ITEMS = 1900;

  typedef struct {
    cmd_t        cmd;
    logic [3:0]  entry;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } beep_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_PATTERN_LENGTH;
  logic [7:0]  cfg_data = '0;

  beep_pattern_sequencer uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beep_cmd_t   pending_cmds[$];
  bps_result_t expected_status[$];
  beep_cmd_t   cmd_on_bus;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  bit          pressure_req = 1'b0;
  logic        sink_hold = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          items_queued = 0;
  bps_result_t got_status;
  bps_result_t want_status;

  // Shadow of the sequencer state and its registers.
  logic [15:0] tone_on [16];
  logic [15:0] tone_off [16];
  logic [3:0]  cur_entry = '0;
  logic [7:0]  pass_count = '0;
  logic        in_on_phase = 1'b1;
  logic        is_playing = 1'b0;
  logic [15:0] elapsed = '0;
  logic [4:0]  cfg_len = PATTERN_LENGTH_RESET;
  logic [7:0]  cfg_reps = REPEAT_TOTAL_RESET;

  function automatic bps_result_t step_pattern(beep_cmd_t c);
    bps_result_t res;
    logic [15:0] limit;
    logic [7:0]  passes;
    logic [4:0]  nxt;
    logic        done;
    done = 1'b0;
    case (c.cmd)
      CMD_TICK: begin
        if (is_playing) begin
          limit = in_on_phase ? tone_on[cur_entry] : tone_off[cur_entry];
          passes = (cfg_reps == 8'd0) ? 8'd1 : cfg_reps;
          if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
          if (elapsed >= limit) begin
            elapsed = '0;
            if (in_on_phase) begin
              in_on_phase = 1'b0;
            end else begin
              nxt = {1'b0, cur_entry} + 5'd1;
              if (nxt >= cfg_len || nxt >= 5'd16) begin
                nxt = '0;
                if (pass_count != REPEAT_MAX) pass_count = pass_count + 8'd1;
                if (pass_count >= passes) begin
                  cur_entry = '0;
                  is_playing = 1'b0;
                  done = 1'b1;
                end
              end
              if (!done) begin
                cur_entry = nxt[3:0];
                in_on_phase = 1'b1;
              end
            end
          end
        end
      end
      CMD_LOAD: begin
        if (!is_playing) begin
          tone_on[c.entry] = c.on_ticks;
          tone_off[c.entry] = c.off_ticks;
        end
      end
      CMD_START: begin
        if (cfg_len != 5'd0 && cfg_len <= 5'd16) begin
          cur_entry = '0;
          pass_count = '0;
          in_on_phase = 1'b1;
          is_playing = 1'b1;
          elapsed = '0;
        end
      end
      default: begin
        is_playing = 1'b0;
      end
    endcase
    res.buzzer_level = is_playing && in_on_phase;
    res.busy_res = is_playing;
    res.entry_now = cur_entry;
    res.finished = done;
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_status.push_back(step_pattern(cmd_on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cmd_on_bus = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, cmd_on_bus.off_ticks, cmd_on_bus.on_ticks, cmd_on_bus.entry};
          s_tuser <= cmd_on_bus.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
      if (m_tvalid && m_tready) begin
        got_status = m_tdata[6:0];
        if (expected_status.size() == 0) begin
          $error("status transfer with no expected status: %h", m_tdata);
          fail_count++;
        end else begin
          want_status = expected_status.pop_front();
          check_field("buzzer_level", int'(want_status.buzzer_level),
                      int'(got_status.buzzer_level));
          check_field("busy_res", int'(want_status.busy_res),
                      int'(got_status.busy_res));
          check_field("entry_now", int'(want_status.entry_now),
                      int'(got_status.entry_now));
          check_field("finished", int'(want_status.finished),
                      int'(got_status.finished));
        end
      end
    end
  end

  // The long hold-off lets the sequencer fill up and stall its input.
  initial begin
    wait (pressure_req);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  function automatic void queue_item(cmd_t c, int e, int on_t, int off_t);
    beep_cmd_t it;
    it.cmd = c;
    it.entry = e[3:0];
    it.on_ticks = on_t[15:0];
    it.off_ticks = off_t[15:0];
    pending_cmds.push_back(it);
    items_queued++;
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PATTERN_LENGTH) cfg_len = val[4:0];
    else cfg_reps = val;
  endtask

  task automatic run_phase(int n_items, logic [7:0] len_data, logic [7:0] reps_data,
                           int mode);
    bit len_ok;
    int r;
    drain();
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
      3: begin src_idle_pct = 15; sink_stall_pct = 15; end
      default: begin src_idle_pct = 0; sink_stall_pct = 0; end
    endcase
    write_reg(CFG_PATTERN_LENGTH, len_data);
    write_reg(CFG_REPEAT_TOTAL, reps_data);
    @(negedge clk);
    if (mode == 4) pressure_req = 1'b1;
    len_ok = (len_data[4:0] != 5'd0) && (len_data[4:0] <= 5'd16);
    repeat ($urandom_range(0, 3))
      queue_item(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 4), $urandom_range(0, 4));
    queue_item(CMD_START, $urandom, $urandom, $urandom);
    // Right after a good start the block is playing, so wide durations are ignored.
    if (len_ok) queue_item(CMD_LOAD, $urandom, $urandom, $urandom);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 85) begin
        queue_item(CMD_TICK, $urandom, $urandom, $urandom);
      end else if (r < 90) begin
        queue_item(CMD_START, $urandom, $urandom, $urandom);
        if (len_ok) queue_item(CMD_LOAD, $urandom, $urandom, $urandom);
      end else if (r < 94) begin
        queue_item(CMD_STOP, $urandom, $urandom, $urandom);
      end else begin
        queue_item(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 4),
                   $urandom_range(0, 4));
      end
    end
    queue_item(CMD_STOP, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int phase;
    logic [7:0] len_data;
    logic [7:0] reps_data;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Idle block with a zero pattern length: start, tick and stop change nothing.
    queue_item(CMD_START, 0, 0, 0);
    queue_item(CMD_TICK, 15, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_STOP, 0, 0, 0);
    for (int i = 0; i < 15; i++) queue_item(CMD_LOAD, i, i % 3, (i + 2) % 3);
    queue_item(CMD_LOAD, 15, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(CFG_PATTERN_LENGTH, 8'd2);
    write_reg(CFG_REPEAT_TOTAL, 8'd0);
    @(negedge clk);
    queue_item(CMD_START, 0, 0, 0);
    queue_item(CMD_LOAD, 0, 16'hFFFF, 16'h0000);
    repeat (6) queue_item(CMD_TICK, 0, 0, 0);
    queue_item(CMD_START, 0, 0, 0);
    queue_item(CMD_TICK, 0, 0, 0);
    queue_item(CMD_START, 0, 0, 0);
    queue_item(CMD_TICK, 0, 0, 0);
    queue_item(CMD_STOP, 0, 0, 0);
    queue_item(CMD_LOAD, 15, 1, 2);

    phase = 0;
    while (items_queued < TARGET_ITEMS) begin
      case ($urandom_range(9))
        0: len_data = 8'd0;
        1: len_data = 8'($urandom_range(0, 255));
        2: len_data = 8'd16;
        3, 4: len_data = 8'($urandom_range(5, 15));
        default: len_data = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(7))
        0: reps_data = 8'($urandom_range(0, 255));
        1: reps_data = 8'd255;
        default: reps_data = 8'($urandom_range(0, 3));
      endcase
      if (phase == 5) begin
        run_phase(200, len_data, reps_data, 4);
      end else if (phase == 9) begin
        // Every pass of a one-entry zero-duration pattern takes two ticks.
        drain();
        queue_item(CMD_LOAD, 0, 0, 0);
        run_phase(520, 8'd1, 8'd255, 0);
      end else begin
        run_phase($urandom_range(40, 120), len_data, reps_data, phase % 4);
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
